// ===== src/base64_stream_encoder_defines.svh =====
// ----------------------------------------------------------------------------
// Base64 stream encoder assertion macros
// Shared property macros for the encoder; they are empty when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef BASE64_STREAM_ENCODER_DEFINES_SVH
`define BASE64_STREAM_ENCODER_DEFINES_SVH

`ifndef SYNTHESIS

// The consequent holds in the same cycle as the antecedent
`define B64E_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("b64e: same-cycle check failed");

// The consequent holds in the cycle after the antecedent
`define B64E_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("b64e: next-cycle check failed");

`else

`define B64E_ASSERT_SAME(label, clk, rst, ante, cons)
`define B64E_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== src/b64e_pkg.sv =====
// ----------------------------------------------------------------------------
// Base64 encoder package
// Group record, queue sizing and the character alphabet lookup.
// ----------------------------------------------------------------------------
package b64e_pkg;

   // Group queue between the byte front end and the character back end
   localparam int QUEUE_DEPTH   = 2;
   localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_LEVEL_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] PAD_CHAR = 8'h3d;   // '='

   // One 24-bit group, zero filled, with the number of bytes held before it
   typedef struct packed {
      logic [7:0] g0;
      logic [7:0] g1;
      logic [7:0] g2;
      logic [1:0] held;   // 0..2 bytes pending ahead of the closing byte
      logic       last;   // group closes the stream
   } group_type;

   typedef struct packed {
      logic                     full;
      logic                     empty;
      logic [QUEUE_LEVEL_W-1:0] level;
   } queue_status_type;

   // Map a 6-bit value to the standard alphabet
   function automatic logic [7:0] sextet_char(input logic [5:0] v);
      logic [7:0] wide;
      wide = {2'b00, v};
      if (v < 6'd26) begin
         sextet_char = wide + 8'h41;            // 'A'
      end else if (v < 6'd52) begin
         sextet_char = wide + 8'h47;            // 'a' - 26
      end else if (v < 6'd62) begin
         sextet_char = wide - 8'h04;            // '0' - 52
      end else if (v == 6'd62) begin
         sextet_char = 8'h2b;                   // '+'
      end else begin
         sextet_char = 8'h2f;                   // '/'
      end
   endfunction

endpackage

// ===== src/b64e_front.sv =====
// ----------------------------------------------------------------------------
// Base64 encoder front end
// Accepts bytes, holds a partial group and pushes each closed group.
// ----------------------------------------------------------------------------
module b64e_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [7:0]                 req_tdata,   // [7:0] data_byte
   input  logic                       req_tlast,   // end_of_stream
   input  b64e_pkg::queue_status_type q_status,
   output logic                       push_valid,
   output b64e_pkg::group_type        push_data,
   output logic [1:0]                 held_count
);
   import b64e_pkg::*;

   logic [1:0] count_ff, count_in;
   logic [7:0] pend0_ff, pend0_in;
   logic [7:0] pend1_ff, pend1_in;
   logic       accept;
   logic       closes;

   assign req_tready = !q_status.full;
   assign accept     = req_tvalid && req_tready;
   assign closes     = (count_ff == 2'd2) || req_tlast;
   assign push_valid = accept && closes;
   assign held_count = count_ff;

   // Assemble the group, missing bytes zero
   always_comb begin
      push_data.g0   = (count_ff == 2'd0) ? req_tdata : pend0_ff;
      push_data.g1   = (count_ff == 2'd2) ? pend1_ff :
                       (count_ff == 2'd1) ? req_tdata : 8'h00;
      push_data.g2   = (count_ff == 2'd2) ? req_tdata : 8'h00;
      push_data.held = count_ff;
      push_data.last = req_tlast;
   end

   // Pending byte bookkeeping
   always_comb begin
      count_in = count_ff;
      pend0_in = pend0_ff;
      pend1_in = pend1_ff;
      if (accept) begin
         if (closes) begin
            count_in = 2'd0;
         end else begin
            count_in = count_ff + 2'd1;
            if (count_ff == 2'd0) begin
               pend0_in = req_tdata;
            end else begin
               pend1_in = req_tdata;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      pend0_ff <= pend0_in;
      pend1_ff <= pend1_in;
   end

endmodule

// ===== src/b64e_queue.sv =====
// ----------------------------------------------------------------------------
// Base64 encoder group queue
// Short first-in first-out store of closed groups between front and back.
// ----------------------------------------------------------------------------
module b64e_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push_valid,
   input  b64e_pkg::group_type        push_data,
   input  logic                       pop,
   output b64e_pkg::group_type        pop_data,
   output b64e_pkg::queue_status_type q_status
);
   import b64e_pkg::*;

   group_type                entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_LEVEL_W-1:0] level_ff, level_in;
   logic                     do_push;
   logic                     do_pop;

   assign q_status.full  = (level_ff == QUEUE_LEVEL_W'(QUEUE_DEPTH));
   assign q_status.empty = (level_ff == '0);
   assign q_status.level = level_ff;

   assign do_push  = push_valid && !q_status.full;
   assign do_pop   = pop && !q_status.empty;
   assign pop_data = entries_ff[rd_ptr_ff];

   // Pointer and fill level update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 :
                     wr_ptr_ff + QUEUE_PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 :
                     rd_ptr_ff + QUEUE_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         level_in = level_ff + QUEUE_LEVEL_W'(1);
      end else if (do_pop && !do_push) begin
         level_in = level_ff - QUEUE_LEVEL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   // Group storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== src/b64e_back.sv =====
// ----------------------------------------------------------------------------
// Base64 encoder back end
// Takes one group at a time and sends its four characters through an
// output register, one per transfer.
// ----------------------------------------------------------------------------
module b64e_back (
   input  logic                       clock,
   input  logic                       reset,
   input  b64e_pkg::group_type        pop_data,
   input  b64e_pkg::queue_status_type q_status,
   output logic                       pop,
   output logic                       busy,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [7:0]                 rsp_tdata,   // [7:0] code_char
   output logic                       rsp_tlast    // final_char
);
   import b64e_pkg::*;

   group_type  group_ff, group_in;
   logic [1:0] idx_ff, idx_in;
   logic       busy_ff, busy_in;
   logic       valid_ff, valid_in;
   logic [7:0] char_ff, char_in;
   logic       final_ff, final_in;
   logic       out_free;
   logic       emit;
   logic       last_char;
   logic       load;
   logic [5:0] sextet;
   logic       pad;

   assign out_free  = !valid_ff || rsp_tready;
   assign emit      = busy_ff && out_free;
   assign last_char = (idx_ff == 2'd3);
   assign load      = !q_status.empty && (!busy_ff || (emit && last_char));
   assign pop       = load;
   assign busy      = busy_ff;

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = char_ff;
   assign rsp_tlast  = final_ff;

   // Pick the sextet for the current character
   always_comb begin
      case (idx_ff)
         2'd0:    sextet = group_ff.g0[7:2];
         2'd1:    sextet = {group_ff.g0[1:0], group_ff.g1[7:4]};
         2'd2:    sextet = {group_ff.g1[3:0], group_ff.g2[7:6]};
         default: sextet = group_ff.g2[5:0];
      endcase
   end

   // Short groups end in pads: one byte gives two, two bytes give one
   assign pad = (last_char && (group_ff.held != 2'd2)) ||
                ((idx_ff == 2'd2) && (group_ff.held == 2'd0));

   always_comb begin
      char_in  = char_ff;
      final_in = final_ff;
      if (emit) begin
         char_in  = pad ? PAD_CHAR : sextet_char(sextet);
         final_in = group_ff.last && last_char;
      end
   end

   // Sequencing over the four characters of a group
   always_comb begin
      group_in = group_ff;
      idx_in   = idx_ff;
      busy_in  = busy_ff;
      valid_in = emit ? 1'b1 : (rsp_tready ? 1'b0 : valid_ff);
      if (emit) begin
         idx_in = idx_ff + 2'd1;
         if (last_char) begin
            busy_in = 1'b0;
         end
      end
      if (load) begin
         group_in = pop_data;
         idx_in   = 2'd0;
         busy_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 2'd0;
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      group_ff <= group_in;
      char_ff  <= char_in;
      final_ff <= final_in;
   end

endmodule

// ===== src/base64_stream_encoder.sv =====
// ----------------------------------------------------------------------------
// Base64 stream encoder
// Standard-alphabet base64 encoder with '=' padding for a byte stream.
// ----------------------------------------------------------------------------
// A byte is taken on each req transfer while the two-entry group queue has
// room, so bytes can arrive in consecutive cycles. Every third byte, or a
// byte with req_tlast set, closes a group; the back end then sends four
// characters, one per rsp transfer, through a single output register, with
// rsp_tlast on the fourth character of the closing group. Short final groups
// are zero filled and padded with '='. Three input bytes give four output
// characters, and the output register sends one character per cycle while
// rsp_tready is high; a new group starts in the cycle after the previous
// group's last character, with no gap when the queue holds another group.
// ----------------------------------------------------------------------------
`include "base64_stream_encoder_defines.svh"

module base64_stream_encoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic       req_tlast,   // end_of_stream
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] code_char
   output logic       rsp_tlast    // final_char
);
   import b64e_pkg::*;

   group_type        push_data;
   group_type        pop_data;
   queue_status_type q_status;
   logic             push_valid;
   logic             pop;
   logic             back_busy;
   logic [1:0]       held_count;
   logic             end_transfer;

   b64e_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_status   (q_status),
      .push_valid (push_valid),
      .push_data  (push_data),
      .held_count (held_count)
   );

   b64e_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .pop        (pop),
      .pop_data   (pop_data),
      .q_status   (q_status)
   );

   b64e_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_data   (pop_data),
      .q_status   (q_status),
      .pop        (pop),
      .busy       (back_busy),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // Transfer of the byte that closes a stream
   assign end_transfer = req_tvalid && req_tready && req_tlast;

   // Checks on the internal handoff
   `B64E_ASSERT_NEXT(a_end_clears_pending, clock, reset, end_transfer, held_count == 2'd0)
   `B64E_ASSERT_NEXT(a_idle_back_loads, clock, reset, !back_busy && !q_status.empty, back_busy)
   `B64E_ASSERT_SAME(a_pending_in_range, clock, reset, 1'b1, held_count != 2'd3)
   `B64E_ASSERT_SAME(a_level_in_range, clock, reset, 1'b1, q_status.level <= 2'd2)

endmodule
